// ===== hw/rtl/ldlt_pkg.sv =====
// Package for the LAN device learning table: table sizing, frame check
// constants, status codes and register indexes. No dependencies.
package ldlt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    localparam logic [15:0] MIN_ETH_LEN  = 16'd14;
    localparam logic [15:0] MIN_IPV4_LEN = 16'd34;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  BCAST_BYTE   = 8'hFF;

    localparam logic [31:0] PREFIX_RST = 32'hC0A8_0000;
    localparam logic [31:0] MASK_RST   = 32'hFFFF_0000;

    localparam logic CFG_PREFIX = 1'b0;
    localparam logic CFG_MASK   = 1'b1;

    localparam logic [2:0] ST_TRACKED   = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_MCAST_SRC = 3'd2;
    localparam logic [2:0] ST_BCAST_DST = 3'd3;
    localparam logic [2:0] ST_NOT_IPV4  = 3'd4;
    localparam logic [2:0] ST_OUT_PFX   = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

endpackage

// ===== hw/rtl/lan_device_learning_table_core.sv =====
// LAN device learning table: frame header checks, source MAC lookup over a
// register-based table and per-device packet count / last-seen update.
// Depends on ldlt_pkg.
// Throughput: one word per cycle unless the result is held by i_out_ready low;
// the table lookup, check chain and entry update sit between the input and result registers.
// Reset (synchronous, active low): clears valid bits, fill count, handshake
// state and restores prefix 192.168.0.0 / mask 255.255.0.0.
module lan_device_learning_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_frame_length,
    input  logic [47:0] i_dst_mac,
    input  logic [47:0] i_source_mac,
    input  logic [15:0] i_frame_ethertype,
    input  logic [31:0] i_source_ipv4,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_new_device,
    output logic [3:0]  o_entry_index,
    output logic [31:0] o_device_count,
    output logic [31:0] o_device_ipv4
);

    localparam int D = ldlt_pkg::TABLE_DEPTH;

    // configuration
    logic [31:0] r_prefix;
    logic [31:0] r_mask;

    // input register
    logic        r_in_valid;
    logic [15:0] r_frame_length;
    logic [47:0] r_dst_mac;
    logic [47:0] r_source_mac;
    logic [15:0] r_frame_ethertype;
    logic [31:0] r_source_ipv4;
    logic [31:0] r_now_time;

    // table
    logic [D-1:0]                  r_entry_valid;
    logic [47:0]                   r_entry_mac       [D];
    logic [31:0]                   r_entry_ip        [D];
    logic [31:0]                   r_entry_packets   [D];
    logic [31:0]                   r_entry_last_seen [D];
    logic [ldlt_pkg::USED_W-1:0]   r_entries_used;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic        r_new_device;
    logic [3:0]  r_entry_index;
    logic [31:0] r_device_count;
    logic [31:0] r_device_ipv4;

    logic                        fire;
    logic [D-1:0]                hit;
    logic                        hit_any;
    logic [ldlt_pkg::IDX_W-1:0]  hit_idx;
    logic                        table_full;
    logic [2:0]                  n_status;
    logic                        n_new_device;
    logic [ldlt_pkg::IDX_W-1:0]  sel_idx;
    logic [31:0]                 old_pkts;
    logic [31:0]                 n_pkts;
    logic [31:0]                 n_ip;
    logic                        upd;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // parallel MAC match; entries hold distinct MACs so at most one hits
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < D; i++) begin
            hit[i] = r_entry_valid[i] && (r_entry_mac[i] == r_source_mac);
            if (hit[i]) begin
                hit_idx = hit_idx | ldlt_pkg::IDX_W'(i);
            end
        end
        hit_any = |hit;
    end

    assign table_full = (r_entries_used == ldlt_pkg::USED_W'(D));

    always_comb begin
        priority if (r_frame_length < ldlt_pkg::MIN_ETH_LEN) begin
            n_status = ldlt_pkg::ST_SHORT;
        end else if (r_source_mac[40]) begin
            n_status = ldlt_pkg::ST_MCAST_SRC;
        end else if (r_dst_mac[47:40] == ldlt_pkg::BCAST_BYTE) begin
            n_status = ldlt_pkg::ST_BCAST_DST;
        end else if (r_frame_ethertype != ldlt_pkg::ETYPE_IPV4
                     || r_frame_length < ldlt_pkg::MIN_IPV4_LEN) begin
            n_status = ldlt_pkg::ST_NOT_IPV4;
        end else if ((r_source_ipv4 & r_mask) != (r_prefix & r_mask)) begin
            n_status = ldlt_pkg::ST_OUT_PFX;
        end else if (!hit_any && table_full) begin
            n_status = ldlt_pkg::ST_FULL;
        end else begin
            n_status = ldlt_pkg::ST_TRACKED;
        end
    end

    always_comb begin
        n_new_device = !hit_any;
        sel_idx      = hit_any ? hit_idx : r_entries_used[ldlt_pkg::IDX_W-1:0];
        old_pkts     = hit_any ? r_entry_packets[hit_idx] : 32'd0;
        n_pkts       = (&old_pkts) ? old_pkts : old_pkts + 32'd1;
        n_ip         = hit_any ? r_entry_ip[hit_idx] : r_source_ipv4;
        upd          = fire && (n_status == ldlt_pkg::ST_TRACKED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= ldlt_pkg::PREFIX_RST;
            r_mask   <= ldlt_pkg::MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ldlt_pkg::CFG_PREFIX: r_prefix <= i_cfg_data;
                ldlt_pkg::CFG_MASK:   r_mask   <= i_cfg_data;
                default:              r_prefix <= r_prefix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_frame_length    <= i_frame_length;
            r_dst_mac         <= i_dst_mac;
            r_source_mac      <= i_source_mac;
            r_frame_ethertype <= i_frame_ethertype;
            r_source_ipv4     <= i_source_ipv4;
            r_now_time        <= i_now_time;
        end
    end

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid  <= '0;
            r_entries_used <= '0;
        end else if (upd && !hit_any) begin
            r_entry_valid[sel_idx] <= 1'b1;
            r_entries_used         <= r_entries_used + ldlt_pkg::USED_W'(1);
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_entry_packets[sel_idx]   <= n_pkts;
            r_entry_last_seen[sel_idx] <= r_now_time;
            if (!hit_any) begin
                r_entry_mac[sel_idx] <= r_source_mac;
                r_entry_ip[sel_idx]  <= r_source_ipv4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // untracked words report zeros in every field but status
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            if (n_status == ldlt_pkg::ST_TRACKED) begin
                r_new_device   <= n_new_device;
                r_entry_index  <= 4'(sel_idx);
                r_device_count <= n_pkts;
                r_device_ipv4  <= n_ip;
            end else begin
                r_new_device   <= 1'b0;
                r_entry_index  <= 4'd0;
                r_device_count <= 32'd0;
                r_device_ipv4  <= 32'd0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_new_device   = r_new_device;
    assign o_entry_index  = r_entry_index;
    assign o_device_count = r_device_count;
    assign o_device_ipv4  = r_device_ipv4;

    // fill count and valid bits must agree (entries fill in order)
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_entry_valid) == 32'(r_entries_used))
        else $error("fill count disagrees with valid bits");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries_used <= ldlt_pkg::USED_W'(D))
        else $error("fill count beyond table depth");

    a_new_dev_allocates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd && !hit_any) |=>
            (r_entries_used == $past(r_entries_used) + ldlt_pkg::USED_W'(1))
            && r_new_device)
        else $error("new device did not take an entry");

    a_untracked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ldlt_pkg::ST_TRACKED) |->
            (!r_new_device && r_device_count == 32'd0 && r_device_ipv4 == 32'd0))
        else $error("untracked word carries entry data");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lan_device_learning_table_core: directed frames, then
// random traffic over several prefix settings, checked against a device table model.
// Depends on ldlt_pkg and the core RTL only.
module tb;

    localparam int MAC_POOL    = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [15:0] len;
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [15:0] etype;
        logic [31:0] sip;
        logic [31:0] stamp;
    } t_frame;

    typedef struct packed {
        logic [2:0]  status;
        logic        fresh;
        logic [3:0]  index;
        logic [31:0] count;
        logic [31:0] ip;
    } t_verdict;

    typedef struct packed {
        t_frame     f;
        logic       typed;
        logic [2:0] st;
    } t_plan_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = ldlt_pkg::CFG_PREFIX;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] frame_length = '0;
    logic [47:0] dst_mac = '0;
    logic [47:0] source_mac = '0;
    logic [15:0] frame_ethertype = '0;
    logic [31:0] source_ipv4 = '0;
    logic [31:0] now_time = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic        new_device;
    logic [3:0]  entry_index;
    logic [31:0] device_count;
    logic [31:0] device_ipv4;

    lan_device_learning_table_core dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_frame_length    (frame_length),
        .i_dst_mac         (dst_mac),
        .i_source_mac      (source_mac),
        .i_frame_ethertype (frame_ethertype),
        .i_source_ipv4     (source_ipv4),
        .i_now_time        (now_time),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (status),
        .o_new_device      (new_device),
        .o_entry_index     (entry_index),
        .o_device_count    (device_count),
        .o_device_ipv4     (device_ipv4)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // device table model
    logic [31:0] filt_prefix = ldlt_pkg::PREFIX_RST;
    logic [31:0] filt_mask   = ldlt_pkg::MASK_RST;
    logic        dev_valid [ldlt_pkg::TABLE_DEPTH];
    logic [47:0] dev_mac   [ldlt_pkg::TABLE_DEPTH];
    logic [31:0] dev_ip    [ldlt_pkg::TABLE_DEPTH];
    logic [31:0] dev_count [ldlt_pkg::TABLE_DEPTH];
    logic [31:0] dev_seen  [ldlt_pkg::TABLE_DEPTH];
    int          dev_used = 0;

    t_verdict    pending_verdicts [$];
    t_plan_row   directed_rows [$];
    logic [47:0] mac_pool [MAC_POOL];
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic t_verdict learn_frame(t_frame f);
        t_verdict v;
        int       hit;
        v = '0;
        hit = -1;
        if (f.len < ldlt_pkg::MIN_ETH_LEN) begin
            v.status = ldlt_pkg::ST_SHORT;
        end else if (f.smac[40]) begin
            v.status = ldlt_pkg::ST_MCAST_SRC;
        end else if (f.dmac[47:40] == ldlt_pkg::BCAST_BYTE) begin
            v.status = ldlt_pkg::ST_BCAST_DST;
        end else if (f.etype != ldlt_pkg::ETYPE_IPV4 || f.len < ldlt_pkg::MIN_IPV4_LEN) begin
            v.status = ldlt_pkg::ST_NOT_IPV4;
        end else if ((f.sip & filt_mask) != (filt_prefix & filt_mask)) begin
            v.status = ldlt_pkg::ST_OUT_PFX;
        end else begin
            for (int i = 0; i < ldlt_pkg::TABLE_DEPTH; i++)
                if (hit < 0 && dev_valid[i] && dev_mac[i] == f.smac)
                    hit = i;
            if (hit < 0) begin
                if (dev_used >= ldlt_pkg::TABLE_DEPTH) begin
                    v.status = ldlt_pkg::ST_FULL;
                end else begin
                    hit = dev_used;
                    dev_valid[hit] = 1'b1;
                    dev_mac[hit] = f.smac;
                    dev_ip[hit] = f.sip;
                    dev_count[hit] = '0;
                    dev_used++;
                    v.fresh = 1'b1;
                end
            end
            if (hit >= 0) begin
                if (dev_count[hit] != 32'hFFFF_FFFF)
                    dev_count[hit] = dev_count[hit] + 32'd1;
                dev_seen[hit] = f.stamp;
                v.status = ldlt_pkg::ST_TRACKED;
                v.index = hit[3:0];
                v.count = dev_count[hit];
                v.ip = dev_ip[hit];
            end
        end
        return v;
    endfunction

    // mostly well-formed IPv4 frames from a small MAC pool, the rest broken
    function automatic t_frame random_frame();
        t_frame f;
        int     kind;
        kind = $urandom_range(99);
        f.stamp = $urandom;
        f.dmac = 48'({$urandom, $urandom});
        if (f.dmac[47:40] == ldlt_pkg::BCAST_BYTE)
            f.dmac[47:40] = 8'hFE;
        f.smac = mac_pool[$urandom_range(MAC_POOL - 1)];
        f.etype = ldlt_pkg::ETYPE_IPV4;
        f.len = ($urandom_range(15) == 0) ? 16'($urandom_range(65535, 34))
                                          : 16'($urandom_range(1518, 34));
        f.sip = ($urandom_range(9) == 0) ? $urandom
                                         : (filt_prefix & filt_mask) | ($urandom & ~filt_mask);
        if (kind >= 75) begin
            case (kind % 6)
                0: f.len = 16'($urandom_range(13));
                1: f.smac[40] = 1'b1;
                2: f.dmac[47:40] = ldlt_pkg::BCAST_BYTE;
                3: f.etype = 16'($urandom);
                4: f.len = 16'($urandom_range(33, 14));
                default: begin
                    f.len = 16'($urandom);
                    f.dmac = 48'({$urandom, $urandom});
                    f.smac = 48'({$urandom, $urandom});
                    f.etype = 16'($urandom);
                    f.sip = $urandom;
                end
            endcase
        end
        return f;
    endfunction

    task automatic plan_frame(logic [15:0] len, logic [47:0] dmac, logic [47:0] smac,
                              logic [15:0] etype, logic [31:0] sip, logic [31:0] stamp,
                              logic typed, logic [2:0] st);
        t_plan_row r;
        r.f = '{len: len, dmac: dmac, smac: smac, etype: etype, sip: sip, stamp: stamp};
        r.typed = typed;
        r.st = st;
        directed_rows.push_back(r);
    endtask

    task automatic send_frame(t_frame f, logic typed, logic [2:0] st);
        t_verdict v;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_length <= f.len;
        dst_mac <= f.dmac;
        source_mac <= f.smac;
        frame_ethertype <= f.etype;
        source_ipv4 <= f.sip;
        now_time <= f.stamp;
        do @(posedge clk); while (!in_ready);
        v = learn_frame(f);
        if (typed) begin
            v = '0;
            v.status = st;
        end
        pending_verdicts.push_back(v);
    endtask

    // drop valid, let every result drain, then a short pause before config
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_filter(logic [31:0] pfx, logic [31:0] msk);
        cfg_we <= 1'b1;
        cfg_index <= ldlt_pkg::CFG_PREFIX;
        cfg_data <= pfx;
        @(posedge clk);
        cfg_index <= ldlt_pkg::CFG_MASK;
        cfg_data <= msk;
        @(posedge clk);
        cfg_we <= 1'b0;
        filt_prefix = pfx;
        filt_mask = msk;
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : check_results
        t_verdict want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("word with nothing pending", {45'd0, status}, '0);
            end else begin
                want = pending_verdicts.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 48'(status), 48'(want.status));
                if (new_device !== want.fresh)
                    report_mismatch("new_device", 48'(new_device), 48'(want.fresh));
                if (entry_index !== want.index)
                    report_mismatch("entry_index", 48'(entry_index), 48'(want.index));
                if (device_count !== want.count)
                    report_mismatch("device_count", 48'(device_count), 48'(want.count));
                if (device_ipv4 !== want.ip)
                    report_mismatch("device_ipv4", 48'(device_ipv4), 48'(want.ip));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [31:0] pfx;
        logic [31:0] msk;
        for (int i = 0; i < ldlt_pkg::TABLE_DEPTH; i++) begin
            dev_valid[i] = 1'b0;
            dev_mac[i] = '0;
            dev_ip[i] = '0;
            dev_count[i] = '0;
            dev_seen[i] = '0;
        end
        for (int i = 0; i < MAC_POOL; i++) begin
            mac_pool[i] = 48'({$urandom, $urandom});
            mac_pool[i][40] = 1'b0;
        end

        // rejects first (fixed codes), then learning under the reset prefix
        plan_frame(16'd0, 48'h0, 48'h0, 16'h0, 32'h0, 32'h0, 1'b1, ldlt_pkg::ST_SHORT);
        plan_frame(16'd13, 48'h0200_0000_0001, 48'h0000_0000_0002, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h1, 1'b1, ldlt_pkg::ST_SHORT);
        plan_frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0100_0000_0000, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h2, 1'b1, ldlt_pkg::ST_MCAST_SRC);
        plan_frame(16'd14, 48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF, 32'h3, 1'b1, ldlt_pkg::ST_MCAST_SRC);
        plan_frame(16'd64, 48'hFFFF_FFFF_FFFF, 48'h0200_0000_0003, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h4, 1'b1, ldlt_pkg::ST_BCAST_DST);
        plan_frame(16'd64, 48'hFF00_0000_0000, 48'h0200_0000_0003, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h5, 1'b1, ldlt_pkg::ST_BCAST_DST);
        plan_frame(16'd14, 48'h0123_4567_89AB, 48'h0200_0000_0004, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h6, 1'b1, ldlt_pkg::ST_NOT_IPV4);
        plan_frame(16'd33, 48'h0200_0000_0001, 48'h0200_0000_0004, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'h7, 1'b1, ldlt_pkg::ST_NOT_IPV4);
        plan_frame(16'd60, 48'h0200_0000_0001, 48'h0200_0000_0004, 16'h86DD,
                   32'hC0A8_0001, 32'h8, 1'b1, ldlt_pkg::ST_NOT_IPV4);
        plan_frame(16'd60, 48'h0200_0000_0001, 48'h0200_0000_0004, 16'hFFFF,
                   32'hC0A8_0001, 32'h9, 1'b1, ldlt_pkg::ST_NOT_IPV4);
        plan_frame(16'd34, 48'h0200_0000_0001, 48'h0200_0000_0004, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A7_FFFF, 32'hA, 1'b1, ldlt_pkg::ST_OUT_PFX);
        plan_frame(16'd34, 48'h0200_0000_0001, 48'h0200_0000_0004, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A9_0000, 32'hB, 1'b1, ldlt_pkg::ST_OUT_PFX);
        plan_frame(16'd34, 48'h0200_0000_0001, 48'h0000_0000_0001, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0000, 32'h0, 1'b0, ldlt_pkg::ST_TRACKED);
        plan_frame(16'hFFFF, 48'h0200_0000_0001, 48'h0000_0000_0001, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_FFFF, 32'hFFFF_FFFF, 1'b0, ldlt_pkg::ST_TRACKED);
        plan_frame(16'd100, 48'hFEFF_FFFF_FFFF, 48'h0, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_1234, 32'hC, 1'b0, ldlt_pkg::ST_TRACKED);
        plan_frame(16'd1518, 48'h0, 48'hFEFF_FFFF_FFFF, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_5678, 32'hD, 1'b0, ldlt_pkg::ST_TRACKED);
        plan_frame(16'd0, 48'h0200_0000_0001, 48'h0000_0000_0001, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0001, 32'hE, 1'b1, ldlt_pkg::ST_SHORT);
        plan_frame(16'd1518, 48'h0200_0000_0001, 48'h0000_0000_0001, ldlt_pkg::ETYPE_IPV4,
                   32'hC0A8_0002, 32'hF, 1'b0, ldlt_pkg::ST_TRACKED);

        send_idle_pct = 8;
        recv_idle_pct = 58;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_frame(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].st);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin pfx = ldlt_pkg::PREFIX_RST; msk = ldlt_pkg::MASK_RST; end
                1: begin pfx = '0;            msk = '0;            end
                2: begin pfx = '1;            msk = '1;            end
                3: begin
                    pfx = $urandom;
                    msk = ~(32'hFFFF_FFFF >> $urandom_range(32));
                end
                4: begin pfx = 32'h0A00_0000; msk = 32'hFF00_0000; end
                default: begin pfx = $urandom; msk = $urandom;     end
            endcase
            set_filter(pfx, msk);
            send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 58 : 0;
            recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 8 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_frame(random_frame(), 1'b0, ldlt_pkg::ST_TRACKED);
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
